>>> design/vcu_pkg.sv
package vcu_pkg;

  localparam int MAX_KERNEL_DEF = 7;
  localparam int MAX_COLS_DEF   = 1024;
  localparam int MAX_ROWS_DEF   = 1024;

  localparam int CFG_W      = 11;  // image_rows / image_cols register width
  localparam int KS_W       = 3;   // kernel_size register width
  localparam int CIDX_W     = 2;   // configuration index width
  localparam int DIM_W      = 13;  // holds any clamped dimension up to 4096
  localparam int DATA_W     = 16;
  localparam int PROD_W     = 2 * DATA_W;
  localparam int COEF_IDX_W = 3;
  localparam int RES_W      = 38;
  localparam int POS_W      = 10;
  localparam int FIFO_DEPTH = 8;

  localparam logic [CIDX_W-1:0] REG_IMAGE_ROWS  = 2'd0;
  localparam logic [CIDX_W-1:0] REG_IMAGE_COLS  = 2'd1;
  localparam logic [CIDX_W-1:0] REG_KERNEL_SIZE = 2'd2;

  localparam logic OP_COEF  = 1'b0;
  localparam logic OP_PIXEL = 1'b1;

  // per-cell control
  typedef struct packed {
    logic shift;
    logic coef_we;
    logic use_tap;
  } cell_ctl_t;

  // result tag carried down the pipeline
  typedef struct packed {
    logic             emit;
    logic             too_big;
    logic             last;
    logic [POS_W-1:0] row;
    logic [POS_W-1:0] col;
  } side_t;

  typedef struct packed {
    logic                    err;
    logic                    last;
    logic [POS_W-1:0]        col;
    logic [POS_W-1:0]        row;
    logic signed [RES_W-1:0] result;
  } ow_t;

endpackage

>>> design/vcu_ram.sv
module vcu_ram import vcu_pkg::*; #(
  parameter int WIDTH = DATA_W,
  parameter int DEPTH = MAX_COLS_DEF
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

>>> design/vcu_cell.sv
module vcu_cell import vcu_pkg::*; (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  cell_ctl_t                ctl_i,
  input  logic signed [DATA_W-1:0] pix_i,
  input  logic signed [DATA_W-1:0] coef_i,
  output logic signed [DATA_W-1:0] pix_o,
  output logic signed [PROD_W-1:0] prod_o
);

  logic signed [DATA_W-1:0] pix_q;
  logic signed [DATA_W-1:0] coef_q;
  logic signed [PROD_W-1:0] prod_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pix_q <= '0;
    end else if (ctl_i.shift) begin
      pix_q <= pix_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.coef_we) begin
      coef_q <= coef_i;
    end
    // keep the multiply in its own assignment so it stays signed
    if (ctl_i.use_tap) begin
      prod_q <= pix_q * coef_q;
    end else begin
      prod_q <= '0;
    end
  end

  assign pix_o  = pix_q;
  assign prod_o = prod_q;

endmodule

>>> design/vcu_fifo.sv
module vcu_fifo import vcu_pkg::*; #(
  parameter int DEPTH = FIFO_DEPTH
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       push_i,
  input  ow_t                        din_i,
  input  logic                       pop_i,
  output ow_t                        dout_o,
  output logic                       valid_o,
  output logic [$clog2(DEPTH+1)-1:0] count_o
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int NW = $clog2(DEPTH + 1);

  ow_t           mem_q [DEPTH];
  logic [PW-1:0] head_q, head_d, tail_q, tail_d;
  logic [NW-1:0] cnt_q, cnt_d;
  logic          do_pop;

  assign do_pop = pop_i && (cnt_q != '0);

  always_comb begin
    head_d = head_q;
    tail_d = tail_q;
    cnt_d  = cnt_q;
    if (push_i) begin
      tail_d = (tail_q == PW'(DEPTH - 1)) ? '0 : tail_q + 1'b1;
    end
    if (do_pop) begin
      head_d = (head_q == PW'(DEPTH - 1)) ? '0 : head_q + 1'b1;
    end
    if (push_i && !do_pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (!push_i && do_pop) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_q <= '0;
      tail_q <= '0;
      cnt_q  <= '0;
    end else begin
      head_q <= head_d;
      tail_q <= tail_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[tail_q] <= din_i;
    end
  end

  assign dout_o  = mem_q[head_q];
  assign valid_o = (cnt_q != '0);
  assign count_o = cnt_q;

  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cnt_q == NW'(DEPTH)) |-> !push_i || do_pop)
    else $error("result queue overflow");

  a_cnt_track: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (push_i && !do_pop) |=> cnt_q == $past(cnt_q) + 1'b1)
    else $error("queue count out of step");

  a_valid_cnt: assert property (@(posedge clk_i) disable iff (!rst_ni)
    do_pop && !push_i && (cnt_q == NW'(1)) |=> !valid_o)
    else $error("queue shows a word after draining");

endmodule

>>> design/valid_2d_convolution_unit.sv
// Valid 2D cross-correlation, n x n kernel (n = 1..MAX_KERNEL), no flip.
// Words with tuser = 0 load one coefficient (row in tdata[2:0], column in
// tdata[5:3], value in tdata[21:6]); words with tuser = 1 are pixels in
// raster order. The block takes one word per clock while s_axis_tready is high;
// m_axis_tvalid rises once the pixel that completes a window has passed the
// line-store read on the accepting edge, then window shift, one multiplier per
// window cell, per-row adders, final adder and result queue. Pixels
// live in MAX_KERNEL line-store banks, one per row of the ring, each with one
// write and one read port. A small result queue lets input continue while
// the output side stalls; tready drops only when that queue plus the words
// still in flight would fill it. Stores are not cleared after reset: load
// the kernel before the first pixel.
module valid_2d_convolution_unit import vcu_pkg::*; #(
  parameter int MAX_KERNEL = MAX_KERNEL_DEF,
  parameter int MAX_COLS   = MAX_COLS_DEF,
  parameter int MAX_ROWS   = MAX_ROWS_DEF
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              cfg_we_i,
  input  logic [CIDX_W-1:0] cfg_idx_i,
  input  logic [CFG_W-1:0]  cfg_data_i,
  input  logic              s_axis_tvalid,
  output logic              s_axis_tready,
  // coef_row[2:0], coef_col[5:3], data_value[21:6], zero fill
  input  logic [23:0]       s_axis_tdata,
  // operation
  input  logic              s_axis_tuser,
  output logic              m_axis_tvalid,
  input  logic              m_axis_tready,
  // result_value[37:0], out_row[47:38], out_col[57:48], zero fill
  output logic [63:0]       m_axis_tdata,
  // last_of_frame
  output logic              m_axis_tlast,
  // size_error
  output logic              m_axis_tuser
);

  localparam int KW     = $clog2(MAX_KERNEL + 1);
  localparam int SW     = (MAX_KERNEL > 1) ? $clog2(MAX_KERNEL) : 1;
  localparam int CW     = $clog2(MAX_COLS);
  localparam int RWW    = $clog2(MAX_ROWS);
  localparam int RSUM_W = PROD_W + $clog2(MAX_KERNEL + 1);
  localparam int TSUM_W = RSUM_W + $clog2(MAX_KERNEL + 1);
  localparam int KSH    = RWW + SW;
  localparam int RECIP  = ((2 ** KSH) + MAX_KERNEL - 1) / MAX_KERNEL;
  localparam int RCW    = KSH + 1;
  localparam int NST    = 5;
  localparam int QW     = $clog2(FIFO_DEPTH + 1);

  // configuration
  logic [CFG_W-1:0] rows_q, cols_q;
  logic [KS_W-1:0]  ks_q;
  logic [DIM_W-1:0] rows_c, cols_c, n_ext;
  logic [KW-1:0]    n_c;
  logic             too_big;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rows_q <= CFG_W'(1);
      cols_q <= CFG_W'(1);
      ks_q   <= KS_W'(3);
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        REG_IMAGE_ROWS:  rows_q <= cfg_data_i;
        REG_IMAGE_COLS:  cols_q <= cfg_data_i;
        REG_KERNEL_SIZE: ks_q   <= cfg_data_i[KS_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    if (rows_q == '0)                       rows_c = DIM_W'(1);
    else if (DIM_W'(rows_q) > DIM_W'(MAX_ROWS)) rows_c = DIM_W'(MAX_ROWS);
    else                                    rows_c = DIM_W'(rows_q);
    if (cols_q == '0)                       cols_c = DIM_W'(1);
    else if (DIM_W'(cols_q) > DIM_W'(MAX_COLS)) cols_c = DIM_W'(MAX_COLS);
    else                                    cols_c = DIM_W'(cols_q);
    if (ks_q == '0)                         n_c = KW'(1);
    else if (int'(ks_q) > MAX_KERNEL)       n_c = KW'(MAX_KERNEL);
    else                                    n_c = KW'(ks_q);
  end

  assign n_ext   = DIM_W'(n_c);
  assign too_big = (rows_c < n_ext) || (cols_c < n_ext);

  // input decode
  logic                     in_acc, pix_acc;
  logic [COEF_IDX_W-1:0]    in_kr, in_kc;
  logic signed [DATA_W-1:0] in_v;

  assign in_acc  = s_axis_tvalid && s_axis_tready;
  assign pix_acc = in_acc && (s_axis_tuser == OP_PIXEL);
  assign in_kr   = s_axis_tdata[2:0];
  assign in_kc   = s_axis_tdata[5:3];
  assign in_v    = s_axis_tdata[21:6];

  // raster position
  logic [CW-1:0]       pcol_q, pcol_d;
  logic [RWW-1:0]      prow_q, prow_d;
  logic [DIM_W-1:0]    pc_ext, pr_ext, c_ext, r_ext;
  logic [CW-1:0]       c_cur;
  logic [RWW-1:0]      r_cur;
  logic                last_col, last_pix;
  logic [RWW+RCW-1:0]  quo_full;
  logic [RWW-1:0]      quo;
  logic [RWW:0]        rem;
  logic [SW-1:0]       slot;
  side_t               side_new;

  always_comb begin
    pc_ext   = DIM_W'(pcol_q);
    pr_ext   = DIM_W'(prow_q);
    c_ext    = (pc_ext >= cols_c) ? cols_c - 1'b1 : pc_ext;
    r_ext    = (pr_ext >= rows_c) ? rows_c - 1'b1 : pr_ext;
    c_cur    = c_ext[CW-1:0];
    r_cur    = r_ext[RWW-1:0];
    last_col = pc_ext >= cols_c - 1'b1;
    last_pix = last_col && (pr_ext >= rows_c - 1'b1);

    // ring slot = row mod MAX_KERNEL through a reciprocal multiply
    quo_full = (RWW+RCW)'(r_cur) * (RWW+RCW)'(RECIP);
    quo      = RWW'(quo_full >> KSH);
    rem      = (RWW+1)'(r_cur) - (RWW+1)'(quo * RWW'(MAX_KERNEL));
    if (rem >= (RWW+1)'(MAX_KERNEL)) begin
      rem = rem - (RWW+1)'(MAX_KERNEL);
    end
    slot = SW'(rem);

    side_new.too_big = too_big;
    side_new.last    = last_pix;
    if (too_big) begin
      side_new.emit = pix_acc && last_pix;
      side_new.row  = '0;
      side_new.col  = '0;
    end else begin
      side_new.emit = pix_acc && (r_ext + 1'b1 >= n_ext) && (c_ext + 1'b1 >= n_ext);
      side_new.row  = POS_W'(r_ext + 1'b1 - n_ext);
      side_new.col  = POS_W'(c_ext + 1'b1 - n_ext);
    end

    if (last_col) begin
      pcol_d = '0;
      prow_d = last_pix ? '0 : RWW'(r_ext + 1'b1);
    end else begin
      pcol_d = CW'(c_ext + 1'b1);
      prow_d = r_cur;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pcol_q <= '0;
      prow_q <= '0;
    end else if (pix_acc) begin
      pcol_q <= pcol_d;
      prow_q <= prow_d;
    end
  end

  // line store banks
  logic [DATA_W-1:0] bank_rd [MAX_KERNEL];

  for (genvar b = 0; b < MAX_KERNEL; b++) begin : g_bank
    vcu_ram #(.WIDTH(DATA_W), .DEPTH(MAX_COLS)) u_ram (
      .clk_i   (clk_i),
      .we_i    (pix_acc && (slot == SW'(b))),
      .waddr_i (c_cur),
      .wdata_i (in_v),
      .re_i    (pix_acc),
      .raddr_i (c_cur),
      .rdata_o (bank_rd[b])
    );
  end

  // stage 1 registers
  logic                     s1_pix_q, s1_coef_q;
  logic [COEF_IDX_W-1:0]    s1_kr_q, s1_kc_q;
  logic signed [DATA_W-1:0] s1_v_q;
  logic [SW-1:0]            s1_slot_q;
  side_t                    sd_q [1:NST];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_pix_q  <= 1'b0;
      s1_coef_q <= 1'b0;
      for (int k = 1; k <= NST; k++) begin
        sd_q[k] <= '0;
      end
    end else begin
      s1_pix_q  <= pix_acc;
      s1_coef_q <= in_acc && (s_axis_tuser == OP_COEF);
      sd_q[1]   <= side_new;
      for (int k = 2; k <= NST; k++) begin
        sd_q[k] <= sd_q[k-1];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    s1_kr_q   <= in_kr;
    s1_kc_q   <= in_kc;
    s1_v_q    <= in_v;
    s1_slot_q <= slot;
  end

  // new window column: bottom row is the pixel itself, the rest from the ring
  logic signed [DATA_W-1:0] newcol [MAX_KERNEL];

  always_comb begin
    logic [SW:0] idx;
    for (int s = 0; s < MAX_KERNEL; s++) begin
      idx = (SW+1)'(s1_slot_q) + (SW+1)'(MAX_KERNEL) - (SW+1)'(int'(n_c) - 1 - s);
      if (idx >= (SW+1)'(MAX_KERNEL)) begin
        idx = idx - (SW+1)'(MAX_KERNEL);
      end
      newcol[s] = (s == int'(n_c) - 1) ? s1_v_q : bank_rd[idx[SW-1:0]];
    end
  end

  // window cells
  logic signed [DATA_W-1:0] pix  [MAX_KERNEL][MAX_KERNEL];
  logic signed [PROD_W-1:0] prod [MAX_KERNEL][MAX_KERNEL];

  for (genvar s = 0; s < MAX_KERNEL; s++) begin : g_row
    for (genvar t = 0; t < MAX_KERNEL; t++) begin : g_col
      logic signed [DATA_W-1:0] nb, pin;
      cell_ctl_t                ctl;

      if (t < MAX_KERNEL - 1) begin : g_mid
        assign nb = pix[s][t+1];
      end else begin : g_end
        assign nb = pix[s][t];
      end

      assign pin = ((s < int'(n_c)) && (t == int'(n_c) - 1)) ? newcol[s] : nb;

      assign ctl.shift   = s1_pix_q;
      assign ctl.coef_we = s1_coef_q && (int'(s1_kr_q) == s) && (int'(s1_kc_q) == t);
      assign ctl.use_tap = (s < int'(n_c)) && (t < int'(n_c));

      vcu_cell u_cell (
        .clk_i  (clk_i),
        .rst_ni (rst_ni),
        .ctl_i  (ctl),
        .pix_i  (pin),
        .coef_i (s1_v_q),
        .pix_o  (pix[s][t]),
        .prod_o (prod[s][t])
      );
    end
  end

  // adder stages
  logic signed [RSUM_W-1:0] rsum_d [MAX_KERNEL];
  logic signed [RSUM_W-1:0] rsum_q [MAX_KERNEL];
  logic signed [TSUM_W-1:0] tot_d, tot_q;

  always_comb begin
    for (int s = 0; s < MAX_KERNEL; s++) begin
      rsum_d[s] = '0;
      for (int t = 0; t < MAX_KERNEL; t++) begin
        rsum_d[s] = rsum_d[s] + RSUM_W'(prod[s][t]);
      end
    end
    tot_d = '0;
    for (int s = 0; s < MAX_KERNEL; s++) begin
      tot_d = tot_d + TSUM_W'(rsum_q[s]);
    end
  end

  always_ff @(posedge clk_i) begin
    rsum_q <= rsum_d;
    tot_q  <= tot_d;
  end

  // result queue
  ow_t          q_din, q_dout;
  logic [QW-1:0] q_cnt;
  logic [QW-1:0] inflight;

  always_comb begin
    q_din.err    = sd_q[NST].too_big;
    q_din.last   = sd_q[NST].last;
    q_din.row    = sd_q[NST].row;
    q_din.col    = sd_q[NST].col;
    q_din.result = sd_q[NST].too_big ? '0 : RES_W'(tot_q);
    inflight = '0;
    for (int k = 1; k <= NST; k++) begin
      inflight = inflight + QW'(sd_q[k].emit);
    end
  end

  vcu_fifo #(.DEPTH(FIFO_DEPTH)) u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (sd_q[NST].emit),
    .din_i   (q_din),
    .pop_i   (m_axis_tready),
    .dout_o  (q_dout),
    .valid_o (m_axis_tvalid),
    .count_o (q_cnt)
  );

  assign s_axis_tready = ((QW+1)'(q_cnt) + (QW+1)'(inflight)) < (QW+1)'(FIFO_DEPTH);
  assign m_axis_tdata  = {6'b0, q_dout.col, q_dout.row, q_dout.result};
  assign m_axis_tlast  = q_dout.last;
  assign m_axis_tuser  = q_dout.err;

  a_err_word: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && m_axis_tuser) |-> m_axis_tlast && (m_axis_tdata == '0))
    else $error("size error word carries data");

  a_coef_silent: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_coef_q |-> !sd_q[1].emit)
    else $error("coefficient load produced a result");

  a_credit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ((QW+1)'(q_cnt) + (QW+1)'(inflight)) <= (QW+1)'(FIFO_DEPTH))
    else $error("words in flight exceed queue room");

endmodule

>>> tb/valid_2d_convolution_unit_tb.sv
module valid_2d_convolution_unit_tb;
  import vcu_pkg::*;

  localparam int KMAX = MAX_KERNEL_DEF;
  localparam int CMAX = MAX_COLS_DEF;
  localparam int RMAX = MAX_ROWS_DEF;
  localparam int PRIME_COLS = 12;
  localparam int SETTLE = 24;

  typedef struct {
    logic signed [RES_W-1:0] val;
    logic [POS_W-1:0]        row;
    logic [POS_W-1:0]        col;
    logic                    last;
    logic                    err;
  } conv_res_t;

  typedef struct {
    bit                      is_cfg;
    logic                    op;
    logic [2:0]              a;
    logic [2:0]              b;
    logic [15:0]             v;
    bit                      has_exp;
    logic signed [RES_W-1:0] e_val;
    logic                    e_err;
  } dir_row_t;

  logic              clk_i = 1'b0;
  logic              rst_ni;
  logic              cfg_we_i;
  logic [CIDX_W-1:0] cfg_idx_i;
  logic [CFG_W-1:0]  cfg_data_i;
  logic              s_axis_tvalid;
  logic              s_axis_tready;
  logic [23:0]       s_axis_tdata;
  logic              s_axis_tuser;
  logic              m_axis_tvalid;
  logic              m_axis_tready;
  logic [63:0]       m_axis_tdata;
  logic              m_axis_tlast;
  logic              m_axis_tuser;

  valid_2d_convolution_unit u_top (.*);

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  // predictor state
  logic signed [15:0] coef_mem [KMAX][KMAX];
  logic signed [15:0] line_mem [KMAX][CMAX];
  logic signed [15:0] win_mem  [KMAX][KMAX];
  int unsigned        cur_row, cur_col;
  int unsigned        rows_reg, cols_reg, ksize_reg;

  conv_res_t pending_q [$];
  conv_res_t want;
  dir_row_t  dir_tab [16];
  int        errors, words_sent, results_seen, frames_done;
  int        send_idle_pct, recv_stall_pct;

  function automatic int unsigned clampu(int unsigned v, int unsigned hi);
    return (v < 1) ? 1 : ((v > hi) ? hi : v);
  endfunction

  function automatic bit conv_step(input logic op, input logic [2:0] kr, input logic [2:0] kc,
                                   input logic signed [15:0] v, output conv_res_t o);
    int unsigned rows, cols, n, r, c, slot, rs;
    bit last_col, last_pix, too_big, hit;
    longint acc;
    rows = clampu(rows_reg, RMAX);
    cols = clampu(cols_reg, CMAX);
    n = clampu(ksize_reg, KMAX);
    hit = 1'b0;
    o = '{default: '0};
    if (op == OP_COEF) begin
      if (kr < KMAX && kc < KMAX) coef_mem[kr][kc] = v;
      return 1'b0;
    end
    r = (cur_row >= rows) ? rows - 1 : cur_row;
    c = (cur_col >= cols) ? cols - 1 : cur_col;
    last_col = cur_col >= cols - 1;
    last_pix = last_col && (cur_row >= rows - 1);
    too_big = (rows < n) || (cols < n);
    slot = r % KMAX;
    line_mem[slot][c] = v;
    for (int s = 0; s < KMAX; s++)
      for (int t = 0; t + 1 < KMAX; t++) win_mem[s][t] = win_mem[s][t+1];
    for (int s = 0; s < n; s++) begin
      rs = (slot + KMAX - (n - 1 - s)) % KMAX;
      win_mem[s][n-1] = line_mem[rs][c];
    end
    if (too_big) begin
      if (last_pix) begin
        o.last = 1'b1;
        o.err = 1'b1;
        hit = 1'b1;
      end
    end else if (r + 1 >= n && c + 1 >= n) begin
      acc = 0;
      for (int s = 0; s < n; s++)
        for (int t = 0; t < n; t++) acc += longint'(win_mem[s][t]) * longint'(coef_mem[s][t]);
      o.val = acc[RES_W-1:0];
      o.row = POS_W'(r + 1 - n);
      o.col = POS_W'(c + 1 - n);
      o.last = last_pix;
      hit = 1'b1;
    end
    if (last_col) begin
      cur_col = 0;
      cur_row = last_pix ? 0 : r + 1;
      if (last_pix) frames_done++;
    end else begin
      cur_col = c + 1;
      cur_row = r;
    end
    return hit;
  endfunction

  // called at a falling edge, returns at a falling edge with tvalid still high
  task automatic push_word(input logic op, input logic [2:0] kr, input logic [2:0] kc,
                           input logic [15:0] v, input bit use_typed, input conv_res_t typed);
    conv_res_t got;
    if (words_sent < 600) begin
      send_idle_pct = 29;
      recv_stall_pct = 51;
    end else if (words_sent < 1200) begin
      send_idle_pct = 51;
      recv_stall_pct = 29;
    end else begin
      send_idle_pct = 0;
      recv_stall_pct = 0;
    end
    if ($urandom_range(99) < send_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 3)) @(negedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= {2'b00, v, kc, kr};
    s_axis_tuser <= op;
    do @(posedge clk_i); while (!s_axis_tready);
    words_sent++;
    if (conv_step(op, kr, kc, v, got)) pending_q.push_back(use_typed ? typed : got);
    @(negedge clk_i);
  endtask

  task automatic drain();
    s_axis_tvalid <= 1'b0;
    while (pending_q.size() != 0) @(negedge clk_i);
    repeat (SETTLE) @(negedge clk_i);
  endtask

  task automatic cfg_write(input logic [CIDX_W-1:0] idx, input logic [CFG_W-1:0] val);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_data_i <= val;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    @(negedge clk_i);
    if (idx == REG_IMAGE_ROWS) rows_reg = 32'(val);
    else if (idx == REG_IMAGE_COLS) cols_reg = 32'(val);
    else ksize_reg = 32'(val[KS_W-1:0]);
  endtask

  task automatic run_frames(input int nframes);
    conv_res_t none;
    int goal;
    none = '{default: '0};
    goal = frames_done + nframes;
    while (frames_done < goal) begin
      if ($urandom_range(19) == 0)
        push_word(OP_COEF, 3'($urandom_range(7)), 3'($urandom_range(7)), 16'($urandom), 0, none);
      else
        push_word(OP_PIXEL, 3'($urandom), 3'($urandom), 16'($urandom), 0, none);
    end
  endtask

  always @(negedge clk_i) m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);

  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      results_seen++;
      if (pending_q.size() == 0) begin
        $error("result word with nothing pending: tdata=%h", m_axis_tdata);
        errors++;
      end else begin
        want = pending_q.pop_front();
        if ($signed(m_axis_tdata[37:0]) !== want.val) begin
          $error("result_value: expected %0d, got %0d", want.val, $signed(m_axis_tdata[37:0]));
          errors++;
        end
        if (m_axis_tdata[47:38] !== want.row) begin
          $error("out_row: expected %0d, got %0d", want.row, m_axis_tdata[47:38]);
          errors++;
        end
        if (m_axis_tdata[57:48] !== want.col) begin
          $error("out_col: expected %0d, got %0d", want.col, m_axis_tdata[57:48]);
          errors++;
        end
        if (m_axis_tlast !== want.last) begin
          $error("last_of_frame: expected %0b, got %0b", want.last, m_axis_tlast);
          errors++;
        end
        if (m_axis_tuser !== want.err) begin
          $error("size_error: expected %0b, got %0b", want.err, m_axis_tuser);
          errors++;
        end
      end
    end
  end

  initial begin
    #2_000_000;
    $display("valid_2d_convolution_unit_tb: done, errors");
    $finish;
  end

  initial begin
    conv_res_t typed;
    int rr, cc;
    rst_ni = 1'b0;
    cfg_we_i = 1'b0;
    cfg_idx_i = '0;
    cfg_data_i = '0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata = '0;
    s_axis_tuser = 1'b0;
    m_axis_tready = 1'b0;
    errors = 0;
    words_sent = 0;
    results_seen = 0;
    frames_done = 0;
    send_idle_pct = 29;
    recv_stall_pct = 51;
    rows_reg = 1;
    cols_reg = 1;
    ksize_reg = 3;
    cur_row = 0;
    cur_col = 0;
    for (int s = 0; s < KMAX; s++)
      for (int t = 0; t < KMAX; t++) begin
        win_mem[s][t] = '0;
        coef_mem[s][t] = '0;
      end
    typed = '{default: '0};
    repeat (10) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // fill every kernel entry, then prime all line banks with a 1x1 kernel
    // so later windows never pick up unwritten pixels
    cfg_write(REG_IMAGE_ROWS, CFG_W'(KMAX));
    cfg_write(REG_IMAGE_COLS, CFG_W'(PRIME_COLS));
    cfg_write(REG_KERNEL_SIZE, CFG_W'(1));
    for (int s = 0; s < KMAX; s++)
      for (int t = 0; t < KMAX; t++)
        push_word(OP_COEF, 3'(s), 3'(t), 16'($urandom), 0, typed);
    run_frames(1);
    drain();

    // 1x1 images: each pixel closes a frame
    dir_tab = '{
      '{1'b1, OP_COEF,  3'(REG_IMAGE_ROWS),  3'd0, 16'd1,    1'b0, '0, 1'b0},
      '{1'b1, OP_COEF,  3'(REG_IMAGE_COLS),  3'd0, 16'd0,    1'b0, '0, 1'b0},
      '{1'b1, OP_COEF,  3'(REG_KERNEL_SIZE), 3'd0, 16'd1,    1'b0, '0, 1'b0},
      '{1'b0, OP_COEF,  3'd0, 3'd0, 16'h8000,         1'b0, '0, 1'b0},
      '{1'b0, OP_PIXEL, 3'd0, 3'd0, 16'h8000,         1'b1, 38'sd1073741824, 1'b0},
      '{1'b0, OP_PIXEL, 3'd7, 3'd7, 16'h7fff,         1'b1, -38'sd1073709056, 1'b0},
      '{1'b0, OP_COEF,  3'd7, 3'd7, 16'h0005,         1'b0, '0, 1'b0},  // out of range, dropped
      '{1'b0, OP_PIXEL, 3'd0, 3'd0, 16'h0001,         1'b1, -38'sd32768, 1'b0},
      '{1'b0, OP_COEF,  3'd0, 3'd0, 16'h7fff,         1'b0, '0, 1'b0},
      '{1'b0, OP_PIXEL, 3'd0, 3'd0, 16'h8000,         1'b1, -38'sd1073709056, 1'b0},
      '{1'b0, OP_PIXEL, 3'd0, 3'd0, 16'h0000,         1'b1, 38'sd0, 1'b0},
      '{1'b1, OP_COEF,  3'(REG_KERNEL_SIZE), 3'd0, 16'd7,    1'b0, '0, 1'b0},
      '{1'b0, OP_PIXEL, 3'd0, 3'd0, 16'h1234,         1'b1, 38'sd0, 1'b1},  // kernel too big
      '{1'b1, OP_COEF,  3'(REG_KERNEL_SIZE), 3'd0, 16'd0,    1'b0, '0, 1'b0},
      '{1'b0, OP_PIXEL, 3'd0, 3'd0, 16'h0002,         1'b1, 38'sd65534, 1'b0},
      '{1'b0, OP_COEF,  3'd6, 3'd6, 16'hffff,         1'b0, '0, 1'b0}
    };
    foreach (dir_tab[i]) begin
      if (dir_tab[i].is_cfg) begin
        drain();
        cfg_write(dir_tab[i].a[CIDX_W-1:0], CFG_W'(dir_tab[i].v));
      end else begin
        typed = '{val: dir_tab[i].e_val, row: '0, col: '0, last: 1'b1, err: dir_tab[i].e_err};
        push_word(dir_tab[i].op, dir_tab[i].a, dir_tab[i].b, dir_tab[i].v,
                  dir_tab[i].has_exp, typed);
      end
    end
    drain();

    // widest frame, 1x1 kernel; an over-range width saturates
    cfg_write(REG_IMAGE_ROWS, CFG_W'(1));
    cfg_write(REG_IMAGE_COLS, 11'h7ff);
    run_frames(1);
    drain();

    while (words_sent < 1450) begin
      rr = $urandom_range(1, 9);
      cc = $urandom_range(1, PRIME_COLS);
      cfg_write(REG_IMAGE_ROWS, CFG_W'(rr));
      cfg_write(REG_IMAGE_COLS, CFG_W'(cc));
      if ($urandom_range(3) != 0)
        cfg_write(REG_KERNEL_SIZE, CFG_W'($urandom_range(1, (rr < cc ? (rr < 7 ? rr : 7)
                                                                      : (cc < 7 ? cc : 7)))));
      else
        cfg_write(REG_KERNEL_SIZE, CFG_W'($urandom_range(7)));
      run_frames($urandom_range(1, 3));
      drain();
    end

    $display("covered %0d input words, %0d results, %0d frames", words_sent, results_seen,
             frames_done);
    $display("sizes from 1x1 up to 1024 wide, kernels 1..7, size errors and stalls");
    if (errors == 0) begin
      $display("valid_2d_convolution_unit_tb: done, clean");
    end else begin
      $display("valid_2d_convolution_unit_tb: done, errors");
    end
    $finish;
  end

endmodule
